### hdl/hrf_pkg.sv
// hrf_pkg: shared types, widths and constants of the habituating reward fusion block.
// No dependencies; imported by hrf_mac and habituating_reward_fusion.
`default_nettype none

package hrf_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int WEIGHT_BITS = 10;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int W_W         = WEIGHT_BITS + 1;
    localparam int PROD_W      = 2 * Q_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int LEN_W       = 16;
    localparam int CFG_W       = 55;
    localparam int CFG_IDX_W   = 3;
    localparam int TH_W        = 39;

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAZE_ALPHA  = 3'd7;

    // emote classes
    localparam logic [1:0] EMOTE_LOW  = 2'd0;
    localparam logic [1:0] EMOTE_MID  = 2'd1;
    localparam logic [1:0] EMOTE_HIGH = 2'd2;

    // multiplier operation codes
    localparam logic [2:0] OP_SND_SQ   = 3'd0;
    localparam logic [2:0] OP_GAZE_NEW = 3'd1;
    localparam logic [2:0] OP_GAZE_OLD = 3'd2;
    localparam logic [2:0] OP_W_DRUM   = 3'd3;
    localparam logic [2:0] OP_W_HIDE   = 3'd4;
    localparam logic [2:0] OP_W_FACE   = 3'd5;
    localparam logic [2:0] OP_W_SOUND  = 3'd6;
    localparam logic [2:0] OP_W_GAZE   = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CNT  = 5'b00010,
        ST_ENV  = 5'b00100,
        ST_RUN  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic valid;
        logic clear;
    } mac_ctl_t;

    function automatic logic [Q_W-1:0] sat_one(input logic [ACC_W-1:0] v);
        logic [Q_W-1:0] r;
        if (v > ACC_W'(ONE_Q)) begin
            r = ONE_Q;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/hrf_mac.sv
// hrf_mac: shared multiply-accumulate unit with registered product and accumulator.
// Depends on hrf_pkg for widths and the control struct.
`default_nettype none

module hrf_mac
    import hrf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mac_ctl_t          ctl,
    input  wire logic [Q_W-1:0]    op_a,
    input  wire logic [Q_W-1:0]    op_b,
    output logic      [PROD_W-1:0] prod,
    output logic      [ACC_W-1:0]  acc_sum
);

    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    mac_ctl_t          ctl_reg;

    assign prod    = prod_reg;
    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.valid) begin
            prod_reg <= op_a * op_b;
        end
        if (ctl_reg.valid) begin
            acc_reg <= ctl_reg.clear ? ACC_W'(prod_reg) : acc_sum;
        end
    end

endmodule

`default_nettype wire

### hdl/habituating_reward_fusion.sv
// habituating_reward_fusion: top level of the face/sound/gaze reward fusion block.
// Depends on hrf_pkg and hrf_mac.
//
// Usage:
// - s_ channel carries one sensor timestep per transfer; m_ channel returns
//   exactly one result per timestep, in order.
// - cfg_wr_en/cfg_index/cfg_data write the eight settings registers; write
//   them only while no timestep is in flight.
// - Each timestep runs from input transfer to m_tvalid through the face
//   counters, the envelope, the steps on the shared 13x13 multiplier
//   (sound square, two gaze terms, five weighted rewards, then drain), and
//   the classify step that loads the output register, in that order.
// - s_tready is high only while the sequencer idles, so a new timestep is
//   accepted only once the previous one has left the sequencer.
// - The output register holds a result until it is taken; a new timestep
//   may be accepted meanwhile and waits in its final cycle until the
//   register frees, so a stalled receiver stalls the input.
// - aresetn (synchronous, active low) restores register defaults, clears
//   counters, envelope and gaze average, and sets the class to mid.
`default_nettype none

module habituating_reward_fusion
    import hrf_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // face_seen[0], sound_level[13:1], gaze_level[26:14], drum_score[39:27],
    // hide_score[52:40], zeros above
    input  wire logic [55:0]          s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // total_reward[12:0], face_reward_out[25:13], emote_level[27:26],
    // emote_changed[28], zeros above
    output logic      [31:0]          m_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int CW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // settings
    logic [LEN_W-1:0] attack_len_reg, hold_len_reg, miss_limit_reg;
    logic [Q_W-1:0]   attack_step_reg, decay_step_reg, gaze_alpha_reg;
    logic [TH_W-1:0]  thresholds_reg;
    logic [CFG_W-1:0] weights_reg;

    // state
    state_t                state_reg;
    logic [3:0]            step_reg;
    logic [COUNT_BITS-1:0] face_count_reg, miss_count_reg;
    logic [Q_W-1:0]        face_reward_reg, gaze_reward_reg;
    logic [1:0]            emote_class_reg;
    logic                  m_valid_reg;
    logic [31:0]           m_data_reg;

    // latched timestep
    logic           seen_reg;
    logic [Q_W-1:0] snd_reg, gaze_reg, drum_reg, hide_reg;
    logic [Q_W-1:0] snd_r_reg, total_reg;

    mac_ctl_t          mac_ctl;
    logic [Q_W-1:0]    op_a, op_b;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  acc_sum;
    logic [2:0]        op_issue, op_done;
    logic [Q_W-1:0]    up, down, alpha;
    logic [Q_W-1:0]    catch_th, hi_th, lo_th;
    logic [CW-1:0]     cnt_x, atk_x, hold_x;
    logic [1:0]        cls;
    logic              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign up       = sat_one(ACC_W'(attack_step_reg));
    assign down     = sat_one(ACC_W'(decay_step_reg));
    assign alpha    = sat_one(ACC_W'(gaze_alpha_reg));
    assign catch_th = thresholds_reg[12:0];
    assign hi_th    = thresholds_reg[25:13];
    assign lo_th    = thresholds_reg[38:26];

    assign cnt_x  = CW'(face_count_reg);
    assign atk_x  = CW'(attack_len_reg);
    assign hold_x = CW'(hold_len_reg);

    assign op_issue = step_reg[2:0];
    assign op_done  = 3'(step_reg - 4'd1);

    always_comb begin
        mac_ctl.valid = (state_reg == ST_RUN) && !step_reg[3];
        mac_ctl.clear = (op_issue == OP_GAZE_NEW) || (op_issue == OP_W_DRUM);
    end

    always_comb begin
        case (op_issue)
            OP_SND_SQ: begin
                op_a = snd_reg;
                op_b = snd_reg;
            end
            OP_GAZE_NEW: begin
                op_a = alpha;
                op_b = gaze_reg;
            end
            OP_GAZE_OLD: begin
                op_a = ONE_Q - alpha;
                op_b = gaze_reward_reg;
            end
            OP_W_DRUM: begin
                op_a = drum_reg;
                op_b = Q_W'(weights_reg[10:0]);
            end
            OP_W_HIDE: begin
                op_a = hide_reg;
                op_b = Q_W'(weights_reg[21:11]);
            end
            OP_W_FACE: begin
                op_a = face_reward_reg;
                op_b = Q_W'(weights_reg[32:22]);
            end
            OP_W_SOUND: begin
                op_a = snd_r_reg;
                op_b = Q_W'(weights_reg[43:33]);
            end
            OP_W_GAZE: begin
                op_a = gaze_reward_reg;
                op_b = Q_W'(weights_reg[54:44]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        if (total_reg >= hi_th) begin
            cls = EMOTE_HIGH;
        end else if (total_reg < lo_th) begin
            cls = EMOTE_LOW;
        end else begin
            cls = EMOTE_MID;
        end
    end

    hrf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .prod    (prod),
        .acc_sum (acc_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg  <= 16'd4;
            hold_len_reg    <= 16'd2;
            attack_step_reg <= 13'd1024;
            decay_step_reg  <= 13'd228;
            miss_limit_reg  <= 16'd3;
            thresholds_reg  <= 39'd20998079742;
            weights_reg     <= 55'd27909088860905856;
            gaze_alpha_reg  <= 13'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ATTACK_LEN:  attack_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_HOLD_LEN:    hold_len_reg    <= cfg_data[LEN_W-1:0];
                CFG_ATTACK_STEP: attack_step_reg <= cfg_data[Q_W-1:0];
                CFG_DECAY_STEP:  decay_step_reg  <= cfg_data[Q_W-1:0];
                CFG_MISS_LIMIT:  miss_limit_reg  <= cfg_data[LEN_W-1:0];
                CFG_THRESHOLDS:  thresholds_reg  <= cfg_data[TH_W-1:0];
                CFG_WEIGHTS:     weights_reg     <= cfg_data;
                CFG_GAZE_ALPHA:  gaze_alpha_reg  <= cfg_data[Q_W-1:0];
                default: ;
            endcase
        end
    end

    // timestep latch, saturated to one
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            seen_reg <= s_tdata[0];
            snd_reg  <= sat_one(ACC_W'(s_tdata[13:1]));
            gaze_reg <= sat_one(ACC_W'(s_tdata[26:14]));
            drum_reg <= sat_one(ACC_W'(s_tdata[39:27]));
            hide_reg <= sat_one(ACC_W'(s_tdata[52:40]));
        end
        if (state_reg == ST_RUN && step_reg != 4'd0) begin
            if (op_done == OP_SND_SQ) begin
                snd_r_reg <= (snd_reg > catch_th) ? ONE_Q : prod[PROD_W-2:FRAC_BITS];
            end
            if (op_done == OP_W_GAZE) begin
                total_reg <= sat_one(ACC_W'(acc_sum[ACC_W-1:WEIGHT_BITS]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            face_count_reg  <= '0;
            miss_count_reg  <= '0;
            face_reward_reg <= '0;
            gaze_reward_reg <= '0;
            emote_class_reg <= EMOTE_MID;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CNT;
                    end
                end
                ST_CNT: begin
                    if (seen_reg) begin
                        if (face_count_reg != COUNT_MAX) begin
                            face_count_reg <= face_count_reg + 1'b1;
                        end
                        miss_count_reg <= '0;
                    end else if (CW'(miss_count_reg) >= CW'(miss_limit_reg)) begin
                        face_count_reg <= '0;
                        miss_count_reg <= '0;
                    end else if (miss_count_reg != COUNT_MAX) begin
                        miss_count_reg <= miss_count_reg + 1'b1;
                    end
                    state_reg <= ST_ENV;
                end
                ST_ENV: begin
                    if (cnt_x == '0 || (cnt_x >= atk_x && cnt_x >= hold_x)) begin
                        face_reward_reg <= (face_reward_reg > down) ?
                                           face_reward_reg - down : '0;
                    end else if (cnt_x < atk_x) begin
                        face_reward_reg <= sat_one(ACC_W'(face_reward_reg) + ACC_W'(up));
                    end else begin
                        face_reward_reg <= ONE_Q;
                    end
                    step_reg  <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (step_reg != 4'd0 && op_done == OP_GAZE_OLD) begin
                        gaze_reward_reg <= sat_one(ACC_W'(acc_sum[ACC_W-1:FRAC_BITS]));
                    end
                    if (step_reg == 4'd8) begin
                        state_reg <= ST_DONE;
                    end
                    step_reg <= step_reg + 4'd1;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        emote_class_reg <= cls;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {3'b000, (cls != emote_class_reg), cls,
                           face_reward_reg, total_reg};
        end
    end

endmodule

`default_nettype wire
